// ===== hdl/apg_pkg.sv =====
package apg_pkg;

    localparam int MaxPoints   = 64;
    localparam int CordicSteps = 20;
    localparam int CntW        = $clog2(MaxPoints + 1);
    localparam int IdxW        = 6;
    localparam int StepIdxW    = $clog2(CordicSteps);
    localparam logic [24:0] FullCircleQ16 = 25'd23592960;
    localparam logic [31:0] CordicGain    = 32'd2608131496;

    // Datapath values: 32-bit radius times the gain gives 48 guard-bit values;
    // the CORDIC vector can grow past that, so 52 bits keep headroom.
    localparam int VecW = 52;

    // Quotient width for the step: angle (25b) << 24 over 360*D.
    localparam int NumW = 49;
    localparam int DenW = 15;
    localparam int StepW = 41;

    typedef struct packed {
        logic load;        // latch request and start validation
        logic div_start;   // start the step divider
        logic pt_start;    // start the CORDIC for the current point
        logic pt_next;     // advance to the next point index
    } apg_cmd_t;

    typedef struct packed {
        logic req_bad;     // latched request fails the range checks
        logic div_done;
        logic pt_done;
        logic pt_last;     // current point index is the final one
    } apg_sts_t;

    function automatic logic [31:0] atan_turns(input logic [4:0] k);
        logic [31:0] r;
        unique case (k)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001; 5'd31: r = 32'h00000000;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/apg_datapath.sv =====
module apg_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  apg_pkg::apg_cmd_t    cmd,
    output apg_pkg::apg_sts_t    sts,
    input  logic [15:0]          tolerance,
    input  logic [31:0]          in_radius,
    input  logic [24:0]          in_degrees,
    input  logic [15:0]          in_count,
    output logic [32:0]          point_x,
    output logic [32:0]          point_y,
    output logic [5:0]           point_number
);
    import apg_pkg::*;

    logic [31:0]       radius_reg;
    logic [24:0]       degrees_reg;
    logic [15:0]       count_reg;
    logic              bad_reg;
    logic [NumW-1:0]   rem_reg;
    logic [StepW-1:0]  quo_reg;
    logic [DenW-1:0]   den_reg;
    logic [5:0]        div_cnt_reg;
    logic              div_busy_reg;
    logic              div_done_reg;
    logic [6:0]        idx_reg;
    logic [47:0]       phase_acc_reg;
    logic [VecW-1:0]   x0_reg;
    logic signed [VecW-1:0] cx_reg, cy_reg;
    logic signed [32:0]     cz_reg;
    logic [1:0]        quad_reg;
    logic [StepIdxW:0] k_reg;
    logic              cor_busy_reg;
    logic              pt_done_reg;
    logic [32:0]       px_reg, py_reg;

    // Validation: all compares on the latched request.
    logic [32:0] tol_ext, deg_ext, rad_ext, full_plus_tol, deg_diff;
    logic        full_circle;
    logic [DenW-1:0] den_w;
    always_comb begin
        tol_ext       = {17'd0, tolerance};
        deg_ext       = {8'd0, degrees_reg};
        rad_ext       = {1'b0, radius_reg};
        full_plus_tol = {8'd0, FullCircleQ16} + tol_ext;
        deg_diff      = (deg_ext >= {8'd0, FullCircleQ16}) ? deg_ext - {8'd0, FullCircleQ16}
                                                          : {8'd0, FullCircleQ16} - deg_ext;
        full_circle   = (deg_diff <= tol_ext);
        den_w         = 15'(360 * (full_circle ? count_reg[6:0] : (count_reg[6:0] - 7'd1)));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            radius_reg  <= in_radius;
            degrees_reg <= in_degrees;
            count_reg   <= in_count;
        end
        bad_reg <= (rad_ext <= tol_ext) || (deg_ext <= tol_ext) || (deg_ext > full_plus_tol)
                   || (count_reg < 16'd2) || (count_reg > 16'(MaxPoints));
    end

    // Restoring divider, one quotient bit per cycle.
    logic [NumW:0] trial;
    always_comb trial = {rem_reg, quo_reg[StepW-1]} - {{(NumW+1-DenW){1'b0}}, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= 6'(StepW);
        end else if (div_busy_reg) begin
            if (div_cnt_reg == 6'd1) begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
            div_cnt_reg <= div_cnt_reg - 6'd1;
        end
    end

    // Dividend is the angle shifted up by 24 bits. Its top 8 bits are below the
    // smallest divisor, so they start out as the partial remainder and only
    // the low 41 bits are shifted through the quotient register.
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= {41'd0, degrees_reg[24:17]};
            quo_reg <= {degrees_reg[16:0], 24'd0};
            den_reg <= den_w;
        end else if (div_busy_reg) begin
            if (!trial[NumW]) begin
                rem_reg <= trial[NumW-1:0];
                quo_reg <= {quo_reg[StepW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[NumW-2:0], quo_reg[StepW-1]};
                quo_reg <= {quo_reg[StepW-2:0], 1'b0};
            end
        end
    end

    // Point sequencer and CORDIC.
    logic signed [VecW-1:0] dx, dy;
    logic signed [32:0] at;
    always_comb begin
        dx = cy_reg >>> k_reg;
        dy = cx_reg >>> k_reg;
        at = {1'b0, atan_turns(5'(k_reg))};
    end

    logic signed [VecW-1:0] rx, ry;
    logic signed [VecW+1:0] fx, fy;
    always_comb begin
        unique case (quad_reg)
            2'd0: begin rx = cx_reg;  ry = cy_reg;  end
            2'd1: begin rx = -cy_reg; ry = cx_reg;  end
            2'd2: begin rx = -cx_reg; ry = -cy_reg; end
            default: begin rx = cy_reg; ry = -cx_reg; end
        endcase
        fx = ($signed({{2{rx[VecW-1]}}, rx}) + 54'sd32768) >>> 16;
        fy = ($signed({{2{ry[VecW-1]}}, ry}) + 54'sd32768) >>> 16;
    end

    function automatic logic [32:0] sat33(input logic signed [VecW+1:0] v);
        if (v > 54'sd4294967295) return 33'h0FFFFFFFF;
        if (v < -54'sd4294967296) return 33'h100000000;
        return v[32:0];
    endfunction

    logic [63:0] gain_prod;
    always_comb gain_prod = radius_reg * CordicGain;

    logic [31:0] phase;
    always_comb phase = phase_acc_reg[39:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cor_busy_reg <= 1'b0;
            pt_done_reg  <= 1'b0;
        end else if (cmd.pt_start) begin
            cor_busy_reg <= 1'b1;
            pt_done_reg  <= 1'b0;
        end else if (cor_busy_reg && k_reg == (StepIdxW+1)'(CordicSteps)) begin
            cor_busy_reg <= 1'b0;
            pt_done_reg  <= 1'b1;
        end else if (cmd.pt_next) begin
            pt_done_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        x0_reg <= VecW'((gain_prod + 64'd32768) >> 16);
        if (cmd.div_start) begin
            idx_reg       <= '0;
            phase_acc_reg <= '0;
        end else if (cmd.pt_next) begin
            idx_reg       <= idx_reg + 7'd1;
            phase_acc_reg <= phase_acc_reg + 48'(quo_reg);
        end
        if (cmd.pt_start) begin
            cx_reg   <= x0_reg;
            cy_reg   <= '0;
            cz_reg   <= {3'b000, phase[29:0]};
            quad_reg <= phase[31:30];
            k_reg    <= '0;
        end else if (cor_busy_reg && k_reg != (StepIdxW+1)'(CordicSteps)) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - at;
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + at;
            end
            k_reg <= k_reg + 1'b1;
        end else if (cor_busy_reg) begin
            px_reg <= sat33(fx);
            py_reg <= sat33(fy);
        end
    end

    assign sts.req_bad  = bad_reg;
    assign sts.div_done = div_done_reg;
    assign sts.pt_done  = pt_done_reg;
    assign sts.pt_last  = (idx_reg + 7'd1) == count_reg[6:0];
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign point_number = idx_reg[5:0];
endmodule

// ===== hdl/apg_controller.sv =====
module apg_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_last,
    output logic              out_bad,
    output apg_pkg::apg_cmd_t cmd,
    input  apg_pkg::apg_sts_t sts
);
    import apg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_BAD   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_WDIV  = 7'b0010000,
        S_PT    = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   wait_reg;

    // The range checks are registered from the latched request and settle in the cycle after it is latched.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wait_reg  <= (state_reg != S_CHECK) && (state_next == S_CHECK);
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: if (!wait_reg) state_next = sts.req_bad ? S_BAD : S_DIV;
            S_BAD:   if (out_ready) state_next = S_IDLE;
            S_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_WDIV;
            end
            S_WDIV: begin
                if (sts.div_done) begin
                    cmd.pt_start = 1'b1;
                    state_next   = S_PT;
                end
            end
            S_PT: if (sts.pt_done) state_next = S_OUT;
            S_OUT: begin
                if (out_ready) begin
                    if (sts.pt_last) state_next = S_IDLE;
                    else begin
                        cmd.pt_next = 1'b1;
                        state_next  = S_WDIV;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_BAD) || (state_reg == S_OUT);
    assign out_bad   = (state_reg == S_BAD);
    assign out_last  = (state_reg == S_BAD) || sts.pt_last;
endmodule

// ===== hdl/arc_points_generator_unit.sv =====
// Arc point generator. Each input item (radius, swept angle, point count N)
// yields N result items with the points of a circular arc about the origin,
// the first at (radius, 0); a full circle leaves out the repeated endpoint.
// An invalid request yields one item with tuser bad_request and tlast set.
// One request is handled at a time: validation and the serial step divider
// (one quotient bit per cycle), then the shared iterative CORDIC for each
// point, and an output stall holds the next point back. The user must write
// compare_tolerance through cfg_wr_en/cfg_wr_data only while idle; the
// block itself does not enforce this.
module arc_points_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // arc_radius[31:0], arc_degrees[56:32], point_count[72:57], zero fill
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // point_x[32:0], point_y[65:33], point_number[71:66]
    output logic [71:0] m_tdata,
    // bad_request
    output logic        m_tuser,
    output logic        m_tlast
);
    import apg_pkg::*;

    logic [15:0] tol_reg;
    apg_cmd_t    cmd;
    apg_sts_t    sts;
    logic [32:0] px, py;
    logic [5:0]  pn;
    logic        bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= 16'd1;
        else if (cfg_wr_en) tol_reg <= cfg_wr_data;
    end

    apg_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_last(m_tlast), .out_bad(bad),
        .cmd(cmd), .sts(sts)
    );

    apg_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .tolerance(tol_reg),
        .in_radius(s_tdata[31:0]), .in_degrees(s_tdata[56:32]),
        .in_count(s_tdata[72:57]),
        .point_x(px), .point_y(py), .point_number(pn)
    );

    // A bad request carries all-zero coordinates and index.
    assign m_tdata = bad ? 72'd0 : {pn, py, px};
    assign m_tuser = bad;

    // The last flag goes out exactly once per request: with it, the block idles.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after last item");
    // Bad items always close their run.
    a_bad_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("bad item without last");
    // No input is taken while results are pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready during output");
endmodule
